[hw/rtl/srfc_pkg.sv]
// Shared types, constants and the CRC-16 byte update for the sensor reply frame checker.
package srfc_pkg;

    localparam logic [15:0] CRC_INIT    = 16'hFFFF;
    localparam logic [15:0] CRC_POLY    = 16'hA001;
    localparam logic [7:0]  FUNC_READ   = 8'h03;
    localparam logic [7:0]  REPLY_LEN   = 8'd4;
    localparam logic [15:0] MISSING_RAW = 16'hFFFF;

    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    localparam logic [2:0] POS_CODE   = 3'd0;
    localparam logic [2:0] POS_LEN    = 3'd1;
    localparam logic [2:0] POS_CRC_LO = 3'd6;
    localparam logic [2:0] POS_CRC_HI = 3'd7;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_CODE = 2'd1,
        ST_BAD_LEN  = 2'd2,
        ST_BAD_CRC  = 2'd3
    } t_status;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_start;
    } t_req;

    typedef struct packed {
        t_status            status;
        logic [15:0]        humidity_tenths;
        logic               humidity_valid;
        logic signed [15:0] temperature_tenths;
        logic               temperature_valid;
    } t_rsp;

    typedef struct packed {
        logic        code_ok;
        logic        length_ok;
        logic        crc_ok;
        logic [15:0] raw_humidity;
        logic [15:0] raw_temperature;
    } t_frame_rec;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    function automatic logic [15:0] crc_byte(logic [15:0] crc, logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

[hw/rtl/srfc_front.sv]
// Front end: accepts reply bytes, tracks position, runs the CRC and builds frame records.
module srfc_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_req_valid,
    input  srfc_pkg::t_req      i_req,
    output logic                o_req_ready,
    input  srfc_pkg::t_q_stat   i_q_stat,
    output logic                o_push,
    output srfc_pkg::t_frame_rec o_rec
);

    logic [2:0]  r_pos, n_pos;
    logic [15:0] r_crc, n_crc;
    logic        r_code_ok, n_code_ok;
    logic        r_len_ok, n_len_ok;
    logic [7:0]  r_payload [4];
    logic [7:0]  r_crc_lo, n_crc_lo;
    logic        payload_we;
    logic [1:0]  payload_idx;
    logic        acc;
    logic [2:0]  pos;
    logic [15:0] crc_in;
    logic [15:0] crc_nx;

    assign o_req_ready = !i_q_stat.full;
    assign acc         = i_req_valid && o_req_ready;
    assign pos         = i_req.frame_start ? srfc_pkg::POS_CODE : r_pos;
    assign crc_in      = (pos == srfc_pkg::POS_CODE) ? srfc_pkg::CRC_INIT : r_crc;
    assign crc_nx      = srfc_pkg::crc_byte(crc_in, i_req.rx_byte);
    assign payload_idx = pos[1:0] + 2'd2;

    always_comb begin
        n_pos      = r_pos;
        n_crc      = r_crc;
        n_code_ok  = r_code_ok;
        n_len_ok   = r_len_ok;
        n_crc_lo   = r_crc_lo;
        payload_we = 1'b0;
        o_push     = 1'b0;
        if (acc) begin
            case (pos)
                srfc_pkg::POS_CODE: begin
                    n_crc     = crc_nx;
                    n_code_ok = (i_req.rx_byte == srfc_pkg::FUNC_READ);
                    n_pos     = srfc_pkg::POS_LEN;
                end
                srfc_pkg::POS_LEN: begin
                    n_crc    = crc_nx;
                    n_len_ok = (i_req.rx_byte == srfc_pkg::REPLY_LEN);
                    n_pos    = pos + 3'd1;
                end
                srfc_pkg::POS_CRC_LO: begin
                    n_crc_lo = i_req.rx_byte;
                    n_pos    = srfc_pkg::POS_CRC_HI;
                end
                srfc_pkg::POS_CRC_HI: begin
                    n_crc  = srfc_pkg::CRC_INIT;
                    n_pos  = srfc_pkg::POS_CODE;
                    o_push = 1'b1;
                end
                default: begin
                    n_crc      = crc_nx;
                    payload_we = 1'b1;
                    n_pos      = pos + 3'd1;
                end
            endcase
        end
    end

    always_comb begin
        o_rec.code_ok         = r_code_ok;
        o_rec.length_ok       = r_len_ok;
        o_rec.crc_ok          = ({i_req.rx_byte, r_crc_lo} == r_crc);
        o_rec.raw_humidity    = {r_payload[0], r_payload[1]};
        o_rec.raw_temperature = {r_payload[2], r_payload[3]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= srfc_pkg::POS_CODE;
            r_crc     <= srfc_pkg::CRC_INIT;
            r_code_ok <= 1'b0;
            r_len_ok  <= 1'b0;
        end else begin
            r_pos     <= n_pos;
            r_crc     <= n_crc;
            r_code_ok <= n_code_ok;
            r_len_ok  <= n_len_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        r_crc_lo <= n_crc_lo;
        if (payload_we) begin
            r_payload[payload_idx] <= i_req.rx_byte;
        end
    end

`ifndef SYNTHESIS
    a_wrap_to_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && pos == srfc_pkg::POS_CRC_HI) |=> (r_pos == srfc_pkg::POS_CODE
            && r_crc == srfc_pkg::CRC_INIT))
        else $error("position or CRC did not restart after the closing byte");
`endif

endmodule

[hw/rtl/srfc_queue.sv]
// Short queue of frame records between the front end and the result stage.
module srfc_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  srfc_pkg::t_frame_rec i_rec,
    input  logic                 i_pop,
    output srfc_pkg::t_frame_rec o_rec,
    output srfc_pkg::t_q_stat    o_stat
);

    srfc_pkg::t_frame_rec r_mem [srfc_pkg::Q_DEPTH];
    logic [srfc_pkg::Q_AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [srfc_pkg::Q_AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [srfc_pkg::Q_CW-1:0] r_count, n_count;

    localparam logic [srfc_pkg::Q_AW-1:0] LAST = srfc_pkg::Q_AW'(srfc_pkg::Q_DEPTH - 1);
    localparam logic [srfc_pkg::Q_CW-1:0] FULL = srfc_pkg::Q_CW'(srfc_pkg::Q_DEPTH);

    assign o_stat.full  = (r_count == FULL);
    assign o_stat.empty = (r_count == '0);
    assign o_rec        = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_rec;
        end
    end

`ifndef SYNTHESIS
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stat.full |-> !i_push)
        else $error("record pushed into a full queue");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stat.empty |-> !i_pop)
        else $error("record popped from an empty queue");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push && !i_pop |=> r_count == $past(r_count) + 1'b1 && r_count <= FULL)
        else $error("queue count out of step with pushes");
`endif

endmodule

[hw/rtl/srfc_back.sv]
// Result stage: pops frame records, grades the frame and holds the result for the receiver.
module srfc_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  srfc_pkg::t_q_stat    i_q_stat,
    input  srfc_pkg::t_frame_rec i_rec,
    output logic                 o_pop,
    output logic                 o_rsp_valid,
    input  logic                 i_rsp_ready,
    output srfc_pkg::t_rsp       o_rsp
);

    logic           r_valid, n_valid;
    srfc_pkg::t_rsp r_rsp, n_rsp;
    logic           hv, tv;
    logic [15:0]    temp;

    assign o_pop       = !i_q_stat.empty && (!r_valid || i_rsp_ready);
    assign o_rsp_valid = r_valid;
    assign o_rsp       = r_rsp;

    always_comb begin
        n_rsp = r_rsp;
        if (!i_rec.code_ok) begin
            n_rsp.status = srfc_pkg::ST_BAD_CODE;
        end else if (!i_rec.length_ok) begin
            n_rsp.status = srfc_pkg::ST_BAD_LEN;
        end else if (!i_rec.crc_ok) begin
            n_rsp.status = srfc_pkg::ST_BAD_CRC;
        end else begin
            n_rsp.status = srfc_pkg::ST_OK;
        end
        hv = (n_rsp.status == srfc_pkg::ST_OK)
            && (i_rec.raw_humidity != srfc_pkg::MISSING_RAW);
        tv = (n_rsp.status == srfc_pkg::ST_OK)
            && (i_rec.raw_temperature != srfc_pkg::MISSING_RAW);
        if (i_rec.raw_temperature[15]) begin
            temp = 16'd0 - {1'b0, i_rec.raw_temperature[14:0]};
        end else begin
            temp = i_rec.raw_temperature;
        end
        n_rsp.humidity_tenths    = hv ? i_rec.raw_humidity : 16'd0;
        n_rsp.humidity_valid     = hv;
        n_rsp.temperature_tenths = tv ? signed'(temp) : 16'sd0;
        n_rsp.temperature_valid  = tv;
    end

    always_comb begin
        n_valid = r_valid;
        if (o_pop) begin
            n_valid = 1'b1;
        end else if (i_rsp_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_rsp <= n_rsp;
        end
    end

endmodule

[hw/rtl/sensor_reply_frame_checker_top.sv]
// Top level of the sensor reply frame checker: front end, record queue and result stage.
//
// Usage:
//   Request channel (i_req_valid / o_req_ready / i_req) carries one reply byte per
//   request: function code, length, humidity high/low, temperature high/low,
//   CRC low, CRC high. frame_start marks a byte as the function code of a new reply.
//   Response channel (o_rsp_valid / i_rsp_ready / o_rsp) carries one result per
//   eight-byte reply: status, humidity and temperature in tenths with valid flags.
//   Throughput: one request per cycle while o_req_ready is high; the CRC-16 byte
//   update and the compares of the front end complete in the accepting cycle.
//   Result path: the record of the closing CRC byte is written into the queue,
//   then popped into the output register and held there until taken.
//   Stall: while the receiver holds i_rsp_ready low, finished records wait in a
//   two-entry queue; o_req_ready drops only once that queue is full.
//   Reset (i_rst_n low, synchronous): byte position to the function code, CRC to
//   its initial value, queue and output register empty.
module sensor_reply_frame_checker_top (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_req_valid,
    output logic            o_req_ready,
    input  srfc_pkg::t_req  i_req,
    output logic            o_rsp_valid,
    input  logic            i_rsp_ready,
    output srfc_pkg::t_rsp  o_rsp
);

    srfc_pkg::t_q_stat    q_stat;
    srfc_pkg::t_frame_rec push_rec;
    srfc_pkg::t_frame_rec pop_rec;
    logic                 push;
    logic                 pop;

    srfc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .i_req       (i_req),
        .o_req_ready (o_req_ready),
        .i_q_stat    (q_stat),
        .o_push      (push),
        .o_rec       (push_rec)
    );

    srfc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_rec   (push_rec),
        .i_pop   (pop),
        .o_rec   (pop_rec),
        .o_stat  (q_stat)
    );

    srfc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_stat    (q_stat),
        .i_rec       (pop_rec),
        .o_pop       (pop),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .o_rsp       (o_rsp)
    );

endmodule
